[src/tick_counter_with_alarms_macros.svh]
`ifndef TICK_COUNTER_WITH_ALARMS_MACROS_SVH
`define TICK_COUNTER_WITH_ALARMS_MACROS_SVH

// Checks that hold in the same cycle as the condition.
`define TCWA_ASSERT_NOW(label, cond, result, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (result)) \
        else $error(msg);

// Checks that hold in the cycle after the condition.
`define TCWA_ASSERT_NEXT(label, cond, result, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (result)) \
        else $error(msg);

`endif

[src/tcwa_pkg.sv]
`default_nettype none

package tcwa_pkg;

    localparam int DEF_NUM_ALARMS = 8;
    localparam int DEF_VALUE_BITS = 32;
    localparam int MAX_RESULTS    = 8;
    localparam int HW             = $clog2(MAX_RESULTS + 1);

    localparam logic [15:0] TPB_RESET = 16'd1;
    localparam logic [31:0] MAX_RESET = 32'd65535;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef enum logic [2:0] {
        CMD_TICK    = 3'd0,
        CMD_ARM     = 3'd1,
        CMD_CANCEL  = 3'd2,
        CMD_READ    = 3'd3,
        CMD_ELAPSED = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_ACK     = 2'd0,
        KIND_EXPIRED = 2'd1,
        KIND_VALUE   = 2'd2,
        KIND_ELAPSED = 2'd3
    } kind_t;

    typedef enum logic [0:0] {
        REG_TICKS_PER_BASE = 1'b0,
        REG_MAX_VALUE      = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH
    } state_t;

    typedef struct packed {
        kind_t       kind;
        logic        status;
        logic [2:0]  alarm;
        logic [31:0] now;
        logic [31:0] elapsed;
        logic        last;
    } res_t;

    function automatic res_t make_res(kind_t kind, logic status, logic [2:0] alarm,
                                      logic [31:0] now, logic [31:0] elapsed,
                                      logic last);
        res_t r;
        r.kind    = kind;
        r.status  = status;
        r.alarm   = alarm;
        r.now     = now;
        r.elapsed = elapsed;
        r.last    = last;
        return r;
    endfunction

endpackage

`default_nettype wire

[src/tcwa_alarm_mem.sv]
`default_nettype none

module tcwa_alarm_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3,
    parameter int DW    = 64
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[src/tcwa_seq.sv]
`default_nettype none

module tcwa_seq #(
    parameter int NUM_ALARMS = 8,
    parameter int VALUE_BITS = 32,
    parameter int AW         = 3
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [2:0]            cmd,
    input  logic [2:0]            alarm_index,
    input  logic [31:0]           expiry_value,
    input  logic [31:0]           cycle_value,
    input  logic [31:0]           previous_value,
    input  logic [15:0]           ticks_per_base,
    input  logic [VALUE_BITS-1:0] max_eff,
    output logic                  mem_we,
    output logic [AW-1:0]         mem_waddr,
    output logic [2*VALUE_BITS-1:0] mem_wdata,
    output logic                  mem_re,
    output logic [AW-1:0]         mem_raddr,
    input  logic [2*VALUE_BITS-1:0] mem_rdata,
    output logic                  strobe,
    output tcwa_pkg::res_t        res
);

    import tcwa_pkg::*;

    localparam int W  = VALUE_BITS;
    localparam int EW = (VALUE_BITS > 32 ? VALUE_BITS : 32) + 1;

    state_t            state_reg, state_next;
    logic [15:0]       prescale_reg, prescale_next;
    logic [W-1:0]      counter_reg, counter_next;
    logic [NUM_ALARMS-1:0] active_reg, active_next;
    logic [AW-1:0]     scan_reg, scan_next;
    logic [HW-1:0]     hits_reg, hits_next;
    logic              held_valid_reg, held_valid_next;
    logic [2:0]        held_idx_reg, held_idx_next;
    logic              strobe_reg, strobe_next;
    res_t              res_reg, res_next;

    logic              accept;
    logic [15:0]       tpb_eff;
    logic [16:0]       pre_inc;
    logic              base_step;
    logic [EW-1:0]     cnt_ext, mx_ext, exp_ext, cyc_ext, prev_ext, diff;
    logic [W-1:0]      cnt_inc;
    logic              idx_bad;
    logic [AW-1:0]     arm_idx;
    logic [W-1:0]      rd_next, rd_cyc, nx;
    logic [W:0]        sum, mx1;
    logic              hit, scan_last, scan_end;
    logic [AW+2:0]     scan_wide;
    logic [2:0]        scan_idx3;

    assign accept  = start && (state_reg == S_IDLE);
    assign busy    = (state_reg != S_IDLE);

    // A zero base count behaves as one tick per step.
    assign tpb_eff   = (ticks_per_base == 16'd0) ? 16'd1 : ticks_per_base;
    assign pre_inc   = {1'b0, prescale_reg} + 17'd1;
    assign base_step = pre_inc >= {1'b0, tpb_eff};

    assign cnt_ext  = EW'(counter_reg);
    assign mx_ext   = EW'(max_eff);
    assign exp_ext  = EW'(expiry_value);
    assign cyc_ext  = EW'(cycle_value);
    assign prev_ext = EW'(previous_value);
    assign cnt_inc  = (cnt_ext >= mx_ext) ? '0 : counter_reg + W'(1);
    assign diff     = (prev_ext > cnt_ext) ? cnt_ext + mx_ext + EW'(1) - prev_ext
                                           : cnt_ext - prev_ext;

    assign idx_bad = 32'(alarm_index) >= NUM_ALARMS;
    assign arm_idx = AW'(alarm_index);

    assign rd_next = mem_rdata[2*W-1:W];
    assign rd_cyc  = mem_rdata[W-1:0];
    assign sum     = {1'b0, rd_next} + {1'b0, rd_cyc};
    assign mx1     = {1'b0, max_eff} + (W+1)'(1);
    assign nx      = (sum > {1'b0, max_eff}) ? W'(sum - mx1) : sum[W-1:0];

    assign hit       = active_reg[scan_reg] && (rd_next == counter_reg);
    assign scan_last = (scan_reg == AW'(NUM_ALARMS - 1));
    assign scan_end  = scan_last || (hit && (hits_reg == HW'(MAX_RESULTS - 1)));
    assign scan_wide = (AW+3)'(scan_reg);
    assign scan_idx3 = scan_wide[2:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (cmd == CMD_TICK) && base_step)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Entry k is written back while entry k+1 is read, so the read-modify-write
    // of one slot never overlaps another access to the same slot.
    always_comb
    begin
        prescale_next   = prescale_reg;
        counter_next    = counter_reg;
        active_next     = active_reg;
        scan_next       = scan_reg;
        hits_next       = hits_reg;
        held_valid_next = held_valid_reg;
        held_idx_next   = held_idx_reg;
        strobe_next     = 1'b0;
        res_next        = res_reg;
        mem_we          = 1'b0;
        mem_waddr       = scan_reg;
        mem_wdata       = {nx, rd_cyc};
        mem_re          = 1'b0;
        mem_raddr       = scan_reg + AW'(1);
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    strobe_next = 1'b1;
                    case (cmd)
                        CMD_TICK:
                        begin
                            if (base_step)
                            begin
                                strobe_next     = 1'b0;
                                prescale_next   = '0;
                                counter_next    = cnt_inc;
                                mem_re          = 1'b1;
                                mem_raddr       = '0;
                                scan_next       = '0;
                                hits_next       = '0;
                                held_valid_next = 1'b0;
                            end
                            else
                            begin
                                prescale_next = pre_inc[15:0];
                                res_next = make_res(KIND_ACK, STATUS_OK, 3'd0,
                                                    cnt_ext[31:0], 32'd0, 1'b1);
                            end
                        end
                        CMD_ARM:
                        begin
                            if (idx_bad || (exp_ext > mx_ext) || (cyc_ext > mx_ext))
                            begin
                                res_next = make_res(KIND_ACK, STATUS_ERR, 3'd0,
                                                    cnt_ext[31:0], 32'd0, 1'b1);
                            end
                            else
                            begin
                                active_next[arm_idx] = 1'b1;
                                mem_we    = 1'b1;
                                mem_waddr = arm_idx;
                                mem_wdata = {W'(expiry_value), W'(cycle_value)};
                                res_next = make_res(KIND_ACK, STATUS_OK, 3'd0,
                                                    cnt_ext[31:0], 32'd0, 1'b1);
                            end
                        end
                        CMD_CANCEL:
                        begin
                            if (idx_bad)
                            begin
                                res_next = make_res(KIND_ACK, STATUS_ERR, 3'd0,
                                                    cnt_ext[31:0], 32'd0, 1'b1);
                            end
                            else
                            begin
                                active_next[arm_idx] = 1'b0;
                                res_next = make_res(KIND_ACK, STATUS_OK, 3'd0,
                                                    cnt_ext[31:0], 32'd0, 1'b1);
                            end
                        end
                        CMD_READ:
                        begin
                            res_next = make_res(KIND_VALUE, STATUS_OK, 3'd0,
                                                cnt_ext[31:0], 32'd0, 1'b1);
                        end
                        CMD_ELAPSED:
                        begin
                            if (prev_ext > mx_ext)
                            begin
                                res_next = make_res(KIND_ELAPSED, STATUS_ERR, 3'd0,
                                                    cnt_ext[31:0], 32'd0, 1'b1);
                            end
                            else
                            begin
                                res_next = make_res(KIND_ELAPSED, STATUS_OK, 3'd0,
                                                    cnt_ext[31:0], diff[31:0], 1'b1);
                            end
                        end
                        default:
                        begin
                            res_next = make_res(KIND_ACK, STATUS_ERR, 3'd0,
                                                cnt_ext[31:0], 32'd0, 1'b1);
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                mem_re    = !scan_last;
                scan_next = scan_reg + AW'(1);
                if (hit)
                begin
                    if (rd_cyc == '0)
                    begin
                        active_next[scan_reg] = 1'b0;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                    end
                    hits_next       = hits_reg + HW'(1);
                    held_valid_next = 1'b1;
                    held_idx_next   = scan_idx3;
                    // Each expiry is held back until the next one is found or the scan ends, so that
                    // the final one can be marked as last.
                    if (held_valid_reg)
                    begin
                        strobe_next = 1'b1;
                        res_next = make_res(KIND_EXPIRED, STATUS_OK, held_idx_reg,
                                            cnt_ext[31:0], 32'd0, 1'b0);
                    end
                end
            end
            S_FLUSH:
            begin
                strobe_next = 1'b1;
                if (held_valid_reg)
                begin
                    res_next = make_res(KIND_EXPIRED, STATUS_OK, held_idx_reg,
                                        cnt_ext[31:0], 32'd0, 1'b1);
                end
                else
                begin
                    res_next = make_res(KIND_ACK, STATUS_OK, 3'd0,
                                        cnt_ext[31:0], 32'd0, 1'b1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            prescale_reg   <= '0;
            counter_reg    <= '0;
            active_reg     <= '0;
            scan_reg       <= '0;
            hits_reg       <= '0;
            held_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            prescale_reg   <= prescale_next;
            counter_reg    <= counter_next;
            active_reg     <= active_next;
            scan_reg       <= scan_next;
            hits_reg       <= hits_next;
            held_valid_reg <= held_valid_next;
            strobe_reg     <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_idx_reg <= held_idx_next;
        res_reg      <= res_next;
    end

    assign strobe = strobe_reg;
    assign res    = res_reg;

endmodule

`default_nettype wire

[src/tick_counter_with_alarms.sv]
// Commands other than a tick, and a tick that does not step the counter, give one
// result in the cycle after acceptance and leave busy low, so one may follow every cycle.
// A tick that steps the counter scans the alarm memory one slot per cycle, ending early once
// eight alarms have expired; busy covers the scan and a flush and falls with the last result.
// Reset clears the counter, prescaler and active flags and loads 1 and 65535 into the
// registers; the alarm memory is not cleared and only armed slots can match.
`default_nettype none

`include "tick_counter_with_alarms_macros.svh"

module tick_counter_with_alarms #(
    parameter int NUM_ALARMS = tcwa_pkg::DEF_NUM_ALARMS,
    parameter int VALUE_BITS = tcwa_pkg::DEF_VALUE_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  cmd,
    input  logic [2:0]  alarm_index,
    input  logic [31:0] expiry_value,
    input  logic [31:0] cycle_value,
    input  logic [31:0] previous_value,
    output logic        strobe,
    output logic [1:0]  kind,
    output logic        status,
    output logic [2:0]  expired_alarm,
    output logic [31:0] counter_now,
    output logic [31:0] elapsed,
    output logic        last,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    import tcwa_pkg::*;

    localparam int AW = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
    localparam int W  = VALUE_BITS;
    localparam int EW = (VALUE_BITS > 32 ? VALUE_BITS : 32) + 1;

    logic [15:0]     tpb_reg;
    logic [31:0]     max_reg;
    logic [EW-1:0]   max_ext, vmask_ext, eff_ext;
    logic [W-1:0]    max_eff;
    logic            mem_we, mem_re;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    logic [2*W-1:0]  mem_wdata, mem_rdata;
    res_t            res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpb_reg <= TPB_RESET;
            max_reg <= MAX_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TICKS_PER_BASE: tpb_reg <= cfg_data[15:0];
                REG_MAX_VALUE:      max_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // The working maximum is the register limited to what the value width can hold.
    assign max_ext   = EW'(max_reg);
    assign vmask_ext = {EW{1'b1}} >> (EW - W);
    assign eff_ext   = (max_ext > vmask_ext) ? vmask_ext : max_ext;
    assign max_eff   = eff_ext[W-1:0];

    tcwa_alarm_mem #(
        .DEPTH (NUM_ALARMS),
        .AW    (AW),
        .DW    (2 * W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    tcwa_seq #(
        .NUM_ALARMS (NUM_ALARMS),
        .VALUE_BITS (VALUE_BITS),
        .AW         (AW)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .alarm_index    (alarm_index),
        .expiry_value   (expiry_value),
        .cycle_value    (cycle_value),
        .previous_value (previous_value),
        .ticks_per_base (tpb_reg),
        .max_eff        (max_eff),
        .mem_we         (mem_we),
        .mem_waddr      (mem_waddr),
        .mem_wdata      (mem_wdata),
        .mem_re         (mem_re),
        .mem_raddr      (mem_raddr),
        .mem_rdata      (mem_rdata),
        .strobe         (strobe),
        .res            (res)
    );

    assign kind          = res.kind;
    assign status        = res.status;
    assign expired_alarm = res.alarm;
    assign counter_now   = res.now;
    assign elapsed       = res.elapsed;
    assign last          = res.last;

    `TCWA_ASSERT_NEXT(a_single_beat, start && !busy && (cmd != CMD_TICK), strobe && last, "command without a single final beat")
    `TCWA_ASSERT_NOW(a_last_idle, strobe && last, !busy, "final beat while still scanning")
    `TCWA_ASSERT_NOW(a_more_expired, strobe && !last, kind == KIND_EXPIRED, "non-final beat that is not an expiry")
    `TCWA_ASSERT_NOW(a_busy_by_tick, $rose(busy), $past(start && (cmd == CMD_TICK)), "scan without a tick")

endmodule

`default_nettype wire
